>>> sv/sti_pkg.sv
// Shared constants, types and helper functions of the sorted table.
`timescale 1ns / 1ps

package sti_pkg;

  // Table geometry.
  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the channels.
  localparam int KIND_W   = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef logic signed [VALUE_BITS-1:0] elem_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [IDX_W-1:0]             idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_DUMP,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic compare;
    logic apply;
    logic dump_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_go;
    logic last;
  } dp_sts_t;

  // Takes the low VALUE_BITS bits of a port value as a signed element.
  function automatic elem_t to_elem(input logic [VAL_W-1:0] v);
    logic [63:0] w;
    w = 64'(signed'(v));
    return w[VALUE_BITS-1:0];
  endfunction

  // Sign-extends or truncates an element to the port width.
  function automatic logic [VAL_W-1:0] from_elem(input elem_t e);
    logic [63:0] w;
    w = 64'(e);
    return w[VAL_W-1:0];
  endfunction

endpackage

>>> sv/sti_if.sv
// Handshake interfaces of the operation and result channels.
`timescale 1ns / 1ps

interface sti_in_if;
  import sti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sti_out_if;
  import sti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [VAL_W-1:0]  entry_value;
  logic [COUNT_W-1:0]       entry_count;
  logic                     last;

  modport source (output valid, output status, output entry_value, output entry_count,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_value, input entry_count,
                  input last, output ready);
endinterface

>>> sv/sti_ctrl.sv
// Controller state machine that sequences each operation through the datapath.
`timescale 1ns / 1ps

module sti_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sti_pkg::dp_cmd_t cmd,
  input  sti_pkg::dp_sts_t sts
);
  import sti_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (sts.dump_go) begin
          state_nxt = S_DUMP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DUMP: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = sts.last ? S_IDLE : S_DUMP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
      end
      S_DUMP: begin
        cmd.dump_step = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/sti_dp.sv
// Datapath: a row of compare-and-shift cells, the fill count and the result register.
`timescale 1ns / 1ps

module sti_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sti_pkg::dp_cmd_t                  cmd,
  output sti_pkg::dp_sts_t                  sts,
  input  logic [sti_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [sti_pkg::VAL_W-1:0]  in_value,
  output logic [sti_pkg::STATUS_W-1:0]      out_status,
  output logic signed [sti_pkg::VAL_W-1:0]  out_entry_value,
  output logic [sti_pkg::COUNT_W-1:0]       out_entry_count,
  output logic                              out_last
);
  import sti_pkg::*;

  elem_t               cell_r   [DEPTH];
  elem_t               cell_nxt [DEPTH];
  elem_t               below    [DEPTH];
  elem_t               above    [DEPTH];
  logic [DEPTH-1:0]    vld;
  logic [DEPTH-1:0]    lt_r;
  logic [DEPTH-1:0]    eq_r;
  logic [DEPTH-1:0]    prev_lt;
  elem_t               key_r;
  logic [KIND_W-1:0]   kind_r;
  cnt_t                cnt_r;
  cnt_t                cnt_nxt;
  idx_t                idx_r;
  logic                full;
  logic                found;
  logic                dump_last;
  logic                cell_we;
  logic [STATUS_W-1:0] status_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [VAL_W-1:0]    value_r;
  logic [COUNT_W-1:0]  count_r;
  logic                last_r;

  // Latch the operation when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_kind;
      key_r  <= to_elem(in_value);
    end
  end

  // Per-cell neighbors and occupancy.
  always_comb begin
    below[0] = key_r;
    for (int i = 1; i < DEPTH; i++) begin
      below[i] = cell_r[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      above[i] = cell_r[i+1];
    end
    above[DEPTH-1] = cell_r[DEPTH-1];
    for (int i = 0; i < DEPTH; i++) begin
      vld[i] = (CNT_W'(i) < cnt_r);
    end
  end

  // Each occupied cell compares itself against the key.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        lt_r[i] <= vld[i] && (cell_r[i] < key_r);
        eq_r[i] <= vld[i] && (cell_r[i] == key_r);
      end
    end
  end

  assign prev_lt   = {lt_r[DEPTH-2:0], 1'b1};
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign found     = |eq_r;
  assign dump_last = ({1'b0, idx_r} == (cnt_r - CNT_W'(1)));

  // Next cell contents: insert shifts up, remove shifts down, dump rotates.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.dump_step) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) == (cnt_r - CNT_W'(1))) begin
          cell_nxt[i] = cell_r[0];
        end else if (vld[i]) begin
          cell_nxt[i] = above[i];
        end
      end
    end else if (kind_r == KIND_INSERT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!lt_r[i]) begin
          cell_nxt[i] = prev_lt[i] ? key_r : below[i];
        end
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (vld[i] && !lt_r[i]) begin
          cell_nxt[i] = above[i];
        end
      end
    end
  end

  // Result status and count of a single-result operation.
  always_comb begin
    status_nxt = ST_DONE;
    cnt_nxt    = cnt_r;
    cell_we    = cmd.dump_step;
    case (kind_r)
      KIND_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          cell_we = cmd.apply;
        end
      end
      KIND_REMOVE: begin
        if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
          cell_we = cmd.apply;
        end
      end
      KIND_DUMP: begin
        status_nxt = ST_EMPTY;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Cell row.
  always_ff @(posedge clk) begin
    if (cell_we) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.apply) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Dump position.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      idx_r <= '0;
    end else if (cmd.dump_step) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.dump_step) begin
      status_r <= ST_ENTRY;
      value_r  <= from_elem(cell_r[0]);
      count_r  <= COUNT_W'(cnt_r);
      last_r   <= dump_last;
    end else if (cmd.apply) begin
      status_r <= status_nxt;
      value_r  <= '0;
      count_r  <= COUNT_W'(cnt_nxt);
      last_r   <= 1'b1;
    end
  end

  assign sts.dump_go      = (kind_r == KIND_DUMP) && (cnt_r != '0);
  assign sts.last         = last_r;
  assign out_status       = status_r;
  assign out_entry_value  = value_r;
  assign out_entry_count  = count_r;
  assign out_last         = last_r;

endmodule

>>> sv/sorted_table_insert_remove.sv
// Top level of the sorted table: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// Holds up to 64 signed values in ascending order in a row of compare-and-shift
// cells. Each transaction is an insert, a remove of one equal entry, or a dump of
// all entries; the spare operation code changes nothing and answers done. The
// block works on one transaction at a time: after acceptance a compare state
// checks every cell against the key and an apply state shifts the row and
// registers the result, which an insert or remove then presents as its single
// result until it is taken; the block takes a new transaction the cycle after
// the result is taken. A dump rotates the occupied cells by one position per
// entry and registers each entry in a dump step, then holds it on the result
// channel until it is taken before the next dump step. Inserting into a full
// table and removing an absent value leave the table unchanged and are flagged
// in the status field.
module sorted_table_insert_remove (
  input  logic       clk,
  input  logic       rst_n,
  sti_in_if.sink     in_if,
  sti_out_if.source  out_if
);
  import sti_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing.
  sti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Storage and result formation.
  sti_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_if.kind),
    .in_value        (in_if.value),
    .out_status      (out_if.status),
    .out_entry_value (out_if.entry_value),
    .out_entry_count (out_if.entry_count),
    .out_last        (out_if.last)
  );

endmodule

>>> test/sti_checker.sv
// Checker of the sorted table: models the table, predicts results and compares them.
`timescale 1ns / 1ps

module sti_checker (
  input  logic clk,
  input  logic rst_n,
  sti_in_if    in_mon,
  sti_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import sti_pkg::*;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] entry_value;
    logic [COUNT_W-1:0]      entry_count;
    logic                    last;
  } table_result_t;

  // Shadow of the table contents, kept in ascending order.
  elem_t         shadow_vals [DEPTH];
  int            shadow_fill;
  table_result_t expected_results [$];

  function automatic void queue_result(input logic [STATUS_W-1:0] st, input elem_t v,
                                       input logic lst);
    table_result_t r;
    r.status      = st;
    r.entry_value = v;
    r.entry_count = COUNT_W'(shadow_fill);
    r.last        = lst;
    expected_results.push_back(r);
  endfunction

  // Applies one operation to the shadow table and queues the results it causes.
  function automatic void apply_table_op(input logic [KIND_W-1:0] k, input elem_t v);
    int pos;
    pos = 0;
    if (k == KIND_INSERT) begin
      if (shadow_fill >= DEPTH) begin
        queue_result(ST_FULL, '0, 1'b1);
      end else begin
        // The new value goes in front of any equal entries.
        while (pos < shadow_fill && shadow_vals[pos] < v) pos++;
        for (int j = shadow_fill; j > pos; j--) shadow_vals[j] = shadow_vals[j-1];
        shadow_vals[pos] = v;
        shadow_fill++;
        queue_result(ST_DONE, '0, 1'b1);
      end
    end else if (k == KIND_REMOVE) begin
      while (pos < shadow_fill && shadow_vals[pos] != v) pos++;
      if (pos >= shadow_fill) begin
        queue_result(ST_NOT_FOUND, '0, 1'b1);
      end else begin
        for (int j = pos; j + 1 < shadow_fill; j++) shadow_vals[j] = shadow_vals[j+1];
        shadow_fill--;
        queue_result(ST_DONE, '0, 1'b1);
      end
    end else if (k == KIND_DUMP) begin
      if (shadow_fill == 0) begin
        queue_result(ST_EMPTY, '0, 1'b1);
      end else begin
        for (int j = 0; j < shadow_fill; j++)
          queue_result(ST_ENTRY, shadow_vals[j], j == shadow_fill - 1);
      end
    end else begin
      // The spare operation code changes nothing and still answers once.
      queue_result(ST_DONE, '0, 1'b1);
    end
  endfunction

  // Compare accepted results first, then model the accepted operation.
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status      = out_mon.status;
        got.entry_value = out_mon.entry_value;
        got.entry_count = out_mon.entry_count;
        got.last        = out_mon.last;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("Result with nothing expected: status %0d value %0d count %0d last %0b",
                     got.status, got.entry_value, got.entry_count, got.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("Mismatch: expected status %0d value %0d count %0d last %0b,",
                       want.status, want.entry_value, want.entry_count, want.last,
                       " got status %0d value %0d count %0d last %0b",
                       got.status, got.entry_value, got.entry_count, got.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        apply_table_op(in_mon.kind, elem_t'(in_mon.value));
    end
    pending <= expected_results.size();
  end

endmodule

>>> test/testbench.sv
// Top of the sorted table testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import sti_pkg::*;

  // Spare operation code that the block answers without changing the table.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int TOTAL_OPS     = 450;
  localparam int HOLD_AT_OP    = 120;
  localparam int HOLD_CYCLES   = 200;
  localparam int CALM_FROM     = 300;
  localparam int CALM_TO       = 380;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 3000;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   ops_sent;
  int   stall_cycles;
  bit   calm;
  bit   hold_done;
  int   live_vals [$];

  sti_in_if  in_ch ();
  sti_out_if out_ch ();

  sorted_table_insert_remove uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  sti_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random back pressure, one long hold-off, and a calm stretch.
  initial begin
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && ops_sent >= HOLD_AT_OP) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // Offers one operation with random gaps in front and waits until it is taken.
  task automatic send_op(input logic [KIND_W-1:0] k, input logic signed [VAL_W-1:0] v);
    calm = (ops_sent >= CALM_FROM && ops_sent < CALM_TO);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ops_sent++;
    // Track the multiset so removes can aim at stored values.
    if (k == KIND_INSERT && live_vals.size() < DEPTH) begin
      live_vals.push_back(v);
    end else if (k == KIND_REMOVE) begin
      foreach (live_vals[i]) begin
        if (live_vals[i] == v) begin
          live_vals.delete(i);
          break;
        end
      end
    end
  endtask

  // Stops offering until every predicted result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Draws from a small pool of values four times in ten so that equal entries are common.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 8) - 4;
    if (r == 4) begin
      case ($urandom_range(0, 2))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_stored_value();
    if (live_vals.size() != 0 && $urandom_range(0, 99) < 80)
      return live_vals[$urandom_range(0, live_vals.size() - 1)];
    return pick_value();
  endfunction

  task automatic mixed_run(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45)      send_op(KIND_INSERT, pick_value());
      else if (r < 80) send_op(KIND_REMOVE, pick_stored_value());
      else if (r < 92) send_op(KIND_DUMP, $urandom);
      else if (r < 96) send_op(KIND_UNUSED, $urandom);
      else             send_op(KIND_W'($urandom_range(0, 3)), $urandom);
    end
  endtask

  // Fill the table, push past full, then read it all out.
  task automatic fill_run();
    while (live_vals.size() < DEPTH) send_op(KIND_INSERT, pick_value());
    repeat (3) send_op(KIND_INSERT, pick_value());
    send_op(KIND_DUMP, $urandom);
  endtask

  // Empty the table, then poke the empty table.
  task automatic empty_run();
    while (live_vals.size() != 0)
      send_op(KIND_REMOVE, live_vals[$urandom_range(0, live_vals.size() - 1)]);
    send_op(KIND_REMOVE, pick_value());
    send_op(KIND_DUMP, $urandom);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_INSERT;
    in_ch.value  <= '0;
    ops_sent     = 0;
    calm         = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, equal values, the spare code.
    send_op(KIND_DUMP, 0);
    send_op(KIND_REMOVE, 0);
    send_op(KIND_UNUSED, 32'sh5A5A_5A5A);
    send_op(KIND_INSERT, 0);
    send_op(KIND_INSERT, VAL_MAX);
    send_op(KIND_INSERT, VAL_MIN);
    send_op(KIND_INSERT, -1);
    send_op(KIND_INSERT, 0);
    send_op(KIND_INSERT, 1);
    send_op(KIND_INSERT, VAL_MIN);
    send_op(KIND_DUMP, -1);
    send_op(KIND_REMOVE, 0);
    send_op(KIND_REMOVE, 12345);
    send_op(KIND_REMOVE, VAL_MAX);
    send_op(KIND_REMOVE, VAL_MIN);
    send_op(KIND_UNUSED, -1);
    send_op(KIND_DUMP, VAL_MAX);
    send_op(KIND_REMOVE, -1);
    send_op(KIND_REMOVE, 0);
    send_op(KIND_REMOVE, 1);
    send_op(KIND_REMOVE, VAL_MIN);
    send_op(KIND_DUMP, VAL_MIN);

    // Random: a fixed opening that reaches a full table, then random runs.
    mixed_run(20);
    fill_run();
    wait_for_results();
    mixed_run(30);
    empty_run();
    while (ops_sent < TOTAL_OPS) begin
      case ($urandom_range(0, 5))
        0:       fill_run();
        1:       empty_run();
        default: mixed_run(20);
      endcase
    end

    // Let every result drain, then let the block sit idle before the verdict.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sti_pkg.sv
sv/sti_if.sv
sv/sti_ctrl.sv
sv/sti_dp.sv
sv/sorted_table_insert_remove.sv
test/sti_checker.sv
test/testbench.sv
